>>> hdl/bpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int ADDR_W        = 32;
    localparam int COUNT_W       = 13;
    localparam int PAGE_SHIFT    = 12;               // 4096-byte pages
    localparam int PIDX_W        = ADDR_W - PAGE_SHIFT;
    localparam int WORD_BITS     = 32;
    localparam int BIT_W         = 5;                // bit position within a map word
    localparam int DEF_MAX_PAGES = 4096;

    typedef enum logic [1:0] {
        REQ_INIT  = 2'd0,
        REQ_ALLOC = 2'd1,
        REQ_FREE  = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE         = 2'd0,
        ST_OUT_OF_PAGES = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_ADDR_INVALID = 2'd3
    } t_status;

    localparam logic CFG_BASE_ADDR  = 1'b0;
    localparam logic CFG_PAGE_COUNT = 1'b1;

    // First-free search result for one map word.
    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] bit_idx;
    } t_scan_res;

endpackage
`default_nettype wire

>>> hdl/bpa_map_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_map_ram
// Used-page map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bpa_map_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

>>> hdl/bpa_word_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_word_scan
// In-range mask and lowest-free-page pick for one 32-bit map word.
// ----------------------------------------------------------------------------
module bpa_word_scan #(
    parameter int WORD_AW = 7
) (
    input  logic [WORD_AW-1:0]            i_word_idx,
    input  logic [bpa_pkg::COUNT_W-1:0]   i_page_cnt,
    input  logic [bpa_pkg::WORD_BITS-1:0] i_word,
    output logic [bpa_pkg::WORD_BITS-1:0] o_in_range,
    output bpa_pkg::t_scan_res            o_res
);
    import bpa_pkg::*;

    localparam int IW = WORD_AW + BIT_W;
    localparam int CW = (IW > COUNT_W) ? IW : COUNT_W;

    logic [WORD_BITS-1:0] free_bits;

    // page index {word, bit} below the page count
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            o_in_range[b] = CW'({i_word_idx, BIT_W'(b)}) < CW'(i_page_cnt);
        end
    end

    assign free_bits = ~i_word & o_in_range;

    // priority pick, lowest set bit wins
    always_comb begin
        o_res.hit     = |free_bits;
        o_res.bit_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                o_res.bit_idx = BIT_W'(b);
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/bitmap_page_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit physical page allocator over a one-bit-per-page used map held
// in a 32-bit-wide synchronous RAM.
// ----------------------------------------------------------------------------
//  channel   ports                                         handshake
//  -------   --------------------------------------------  -------------------
//  request   i_req_type, i_address                         start & !busy
//  result    o_status, o_page_addr, o_used_count           o_result_vld, 1 cycle
//  config    i_cfg_idx, i_cfg_wdata                        i_cfg_we
//
//  Init writes all W = ceil(MAX_PAGES/32) map words; an alloc examines k
//  map words, 1 <= k <= max(1, ceil(n/32)) with n the effective page
//  count; a free reads one map word, none when the address is invalid;
//  a no-op reads none. The result strobe is high in the first cycle with
//  busy low again; for a no-op, in the cycle after it is taken. Alloc
//  cost is set by the word-at-a-time scan through the single RAM read
//  port, init by the one-word-per-cycle write sweep.
//  After reset a clearing pass sets every map bit (all pages used) with
//  busy high; config writes are taken meanwhile.
//  The receiver cannot stall: o_result_vld is a single-cycle strobe.
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
    parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_req_type,
    input  logic [bpa_pkg::ADDR_W-1:0]    i_address,
    // result
    output logic                          o_result_vld,
    output logic [1:0]                    o_status,
    output logic [bpa_pkg::ADDR_W-1:0]    o_page_addr,
    output logic [bpa_pkg::COUNT_W-1:0]   o_used_count,
    // configuration
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [bpa_pkg::ADDR_W-1:0]    i_cfg_wdata
);
    import bpa_pkg::*;

    localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IW        = WAW + BIT_W;     // page index width
    localparam logic [WAW-1:0] LAST_WORD = WAW'(MAP_WORDS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,       // init / reset clearing pass, one word a cycle
        S_SCAN,        // alloc: pipelined word reads + first-free check
        S_ALLOC_DONE,  // alloc: form page address
        S_FREE_ADDR,   // free: range check, read map word
        S_FREE_CHK     // free: test and clear bit
    } t_state;

    // config registers
    logic [ADDR_W-1:0]  r_base;
    logic [COUNT_W-1:0] r_page_count;

    // control
    t_state             r_state;
    logic [COUNT_W-1:0] r_n;           // effective page count of this transaction
    logic [COUNT_W-1:0] r_used;
    logic [WAW-1:0]     r_sweep_ptr;
    logic               r_sweep_rsp;   // sweep is an init request, not the reset pass
    logic [WAW-1:0]     r_rd_ptr;
    logic               r_iss_on;
    logic               r_chk_vld;
    logic [WAW-1:0]     r_chk_idx;
    logic [WAW-1:0]     r_last;
    logic [BIT_W-1:0]   r_bit;
    logic [IW-1:0]      r_hit_idx;
    logic [ADDR_W-1:0]  r_addr;

    // result registers
    logic               r_out_vld;
    t_status            r_status;
    logic [ADDR_W-1:0]  r_page_addr;
    logic [COUNT_W-1:0] r_used_out;

    // RAM / scan wiring
    logic                 mem_we;
    logic [WAW-1:0]       mem_wr_addr;
    logic [WORD_BITS-1:0] mem_wr_data;
    logic                 mem_rd_en;
    logic [WAW-1:0]       mem_rd_addr;
    logic [WORD_BITS-1:0] mem_rd_data;
    logic [WAW-1:0]       scan_idx;
    logic [WORD_BITS-1:0] in_range;
    t_scan_res            scan_res;

    logic [COUNT_W-1:0]   n_eff;
    logic [WAW-1:0]       last_word;
    logic [ADDR_W:0]      free_diff;
    logic [PIDX_W-1:0]    free_pidx;
    logic                 free_bad;
    logic [WAW-1:0]       free_word;
    logic [COUNT_W-1:0]   used_dec;

    // page_count above MAX_PAGES acts as MAX_PAGES
    assign n_eff = ({{(32 - COUNT_W){1'b0}}, r_page_count} > 32'(MAX_PAGES))
                 ? COUNT_W'(MAX_PAGES) : r_page_count;
    assign last_word = (n_eff == '0) ? '0 : WAW'((n_eff - COUNT_W'(1)) >> BIT_W);

    // free: page index relative to base, borrow flags an address below base
    assign free_diff = {1'b0, r_addr} - {1'b0, r_base};
    assign free_pidx = free_diff[ADDR_W-1:PAGE_SHIFT];
    assign free_bad  = free_diff[ADDR_W] ||
                       (free_pidx >= {{(PIDX_W - COUNT_W){1'b0}}, r_n});
    assign free_word = free_pidx[IW-1:BIT_W];
    assign used_dec  = (r_used != '0) ? (r_used - COUNT_W'(1)) : r_used;

    bpa_map_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (WAW),
        .DW    (WORD_BITS)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    bpa_word_scan #(
        .WORD_AW (WAW)
    ) u_word_scan (
        .i_word_idx (scan_idx),
        .i_page_cnt (r_n),
        .i_word     (mem_rd_data),
        .o_in_range (in_range),
        .o_res      (scan_res)
    );

    // RAM port control
    always_comb begin
        mem_we      = 1'b0;
        mem_wr_addr = r_chk_idx;
        mem_wr_data = mem_rd_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_rd_ptr;
        scan_idx    = r_chk_idx;
        case (r_state)
            S_SWEEP: begin
                // used everywhere except pages 1 .. n-1 (page 0 holds the map)
                scan_idx    = r_sweep_ptr;
                mem_we      = 1'b1;
                mem_wr_addr = r_sweep_ptr;
                mem_wr_data = ~in_range |
                              ((r_sweep_ptr == '0) ? WORD_BITS'(1) : '0);
            end
            S_SCAN: begin
                mem_rd_en = r_iss_on;
                if (r_chk_vld && scan_res.hit) begin
                    mem_we      = 1'b1;
                    mem_wr_data = mem_rd_data | (WORD_BITS'(1) << scan_res.bit_idx);
                end
            end
            S_FREE_ADDR: begin
                mem_rd_en   = ~free_bad;
                mem_rd_addr = free_word;
            end
            S_FREE_CHK: begin
                if (mem_rd_data[r_bit]) begin
                    mem_we      = 1'b1;
                    mem_wr_data = mem_rd_data & ~(WORD_BITS'(1) << r_bit);
                end
            end
            default: begin
            end
        endcase
    end

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_page_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_ADDR:  r_base       <= i_cfg_wdata;
                CFG_PAGE_COUNT: r_page_count <= i_cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;   // reset clearing pass
            r_sweep_ptr <= '0;
            r_sweep_rsp <= 1'b0;
            r_n         <= '0;        // n = 0 sweeps all ones
            r_used      <= '0;
            r_iss_on    <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_addr <= i_address;
                        r_n    <= n_eff;
                        case (t_req'(i_req_type))
                            REQ_INIT: begin
                                r_sweep_ptr <= '0;
                                r_sweep_rsp <= 1'b1;
                                r_state     <= S_SWEEP;
                            end
                            REQ_ALLOC: begin
                                r_rd_ptr  <= '0;
                                r_iss_on  <= 1'b1;
                                r_chk_vld <= 1'b0;
                                r_last    <= last_word;
                                r_state   <= S_SCAN;
                            end
                            REQ_FREE: begin
                                r_state <= S_FREE_ADDR;
                            end
                            default: begin
                                r_out_vld   <= 1'b1;
                                r_status    <= ST_DONE;
                                r_page_addr <= '0;
                                r_used_out  <= r_used;
                            end
                        endcase
                    end
                end
                S_SWEEP: begin
                    if (r_sweep_ptr == LAST_WORD) begin
                        r_state <= S_IDLE;
                        if (r_sweep_rsp) begin
                            r_used      <= COUNT_W'(r_n != '0);
                            r_out_vld   <= 1'b1;
                            r_status    <= ST_DONE;
                            r_page_addr <= '0;
                            r_used_out  <= COUNT_W'(r_n != '0);
                        end
                    end else begin
                        r_sweep_ptr <= r_sweep_ptr + WAW'(1);
                    end
                end
                S_SCAN: begin
                    // issue side
                    r_chk_vld <= r_iss_on;
                    r_chk_idx <= r_rd_ptr;
                    if (r_iss_on) begin
                        if (r_rd_ptr == r_last) begin
                            r_iss_on <= 1'b0;
                        end else begin
                            r_rd_ptr <= r_rd_ptr + WAW'(1);
                        end
                    end
                    // check side; a read still in flight is dropped
                    if (r_chk_vld) begin
                        if (scan_res.hit) begin
                            r_hit_idx <= {r_chk_idx, scan_res.bit_idx};
                            r_used    <= r_used + COUNT_W'(1);
                            r_iss_on  <= 1'b0;
                            r_state   <= S_ALLOC_DONE;
                        end else if (r_chk_idx == r_last) begin
                            r_iss_on    <= 1'b0;
                            r_out_vld   <= 1'b1;
                            r_status    <= ST_OUT_OF_PAGES;
                            r_page_addr <= '0;
                            r_used_out  <= r_used;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                S_ALLOC_DONE: begin
                    r_out_vld   <= 1'b1;
                    r_status    <= ST_DONE;
                    r_page_addr <= r_base + ADDR_W'({r_hit_idx, {PAGE_SHIFT{1'b0}}});
                    r_used_out  <= r_used;
                    r_state     <= S_IDLE;
                end
                S_FREE_ADDR: begin
                    if (free_bad) begin
                        r_out_vld   <= 1'b1;
                        r_status    <= ST_ADDR_INVALID;
                        r_page_addr <= '0;
                        r_used_out  <= r_used;
                        r_state     <= S_IDLE;
                    end else begin
                        r_chk_idx <= free_word;
                        r_bit     <= free_pidx[BIT_W-1:0];
                        r_state   <= S_FREE_CHK;
                    end
                end
                S_FREE_CHK: begin
                    r_out_vld   <= 1'b1;
                    r_page_addr <= '0;
                    r_state     <= S_IDLE;
                    if (mem_rd_data[r_bit]) begin
                        r_used     <= used_dec;
                        r_status   <= ST_DONE;
                        r_used_out <= used_dec;
                    end else begin
                        r_status   <= ST_ALREADY_FREE;
                        r_used_out <= r_used;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_result_vld = r_out_vld;
    assign o_status     = r_status;
    assign o_page_addr  = r_page_addr;
    assign o_used_count = r_used_out;

endmodule
`default_nettype wire

>>> bench/bpa_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_result_checker
// Watches the request, config and result channels of the page allocator,
// keeps its own copy of the used map and queues one predicted result per
// accepted request; each result strobe is compared against the oldest one.
// ----------------------------------------------------------------------------
module bpa_result_checker #(
    parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [1:0]                    i_req_type,
    input  logic [bpa_pkg::ADDR_W-1:0]    i_address,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [bpa_pkg::ADDR_W-1:0]    i_cfg_wdata,
    input  logic                          i_result_vld,
    input  logic [1:0]                    i_status,
    input  logic [bpa_pkg::ADDR_W-1:0]    i_page_addr,
    input  logic [bpa_pkg::COUNT_W-1:0]   i_used_count,
    output int                            o_fail_cnt,
    output int                            o_pending
);
    import bpa_pkg::*;

    typedef struct packed {
        t_status              status;
        logic [ADDR_W-1:0]    page_addr;
        logic [COUNT_W-1:0]   used_count;
    } t_page_result;

    logic [ADDR_W-1:0]  base_addr_q  = '0;
    logic [COUNT_W-1:0] page_count_q = '0;
    bit                 used_map [MAX_PAGES];
    int unsigned        used_total   = 0;
    t_page_result       page_results [$];
    int                 fail_cnt     = 0;

    assign o_fail_cnt = fail_cnt;

    initial begin
        o_pending = 0;
        foreach (used_map[i]) used_map[i] = 1'b1;
    end

    // Apply one request to the shadow map and return what the block must report.
    function automatic t_page_result serve_request(t_req req, logic [ADDR_W-1:0] addr);
        int unsigned       n;
        int unsigned       reserve;
        int unsigned       idx;
        logic [ADDR_W-1:0] offset;
        bit                found;
        t_page_result      res;
        n              = (page_count_q > MAX_PAGES) ? MAX_PAGES : page_count_q;
        found          = 1'b0;
        res.status     = ST_DONE;
        res.page_addr  = '0;
        case (req)
            REQ_INIT: begin
                // the lowest page stays reserved for the map itself
                reserve = (n + 32767) / 32768;
                for (int i = 0; i < MAX_PAGES; i++)
                    used_map[i] = (i < reserve) || (i >= n);
                used_total = (reserve < n) ? reserve : n;
            end
            REQ_ALLOC: begin
                res.status = ST_OUT_OF_PAGES;
                for (int i = 0; i < n && !found; i++) begin
                    if (!used_map[i]) begin
                        found         = 1'b1;
                        used_map[i]   = 1'b1;
                        used_total++;
                        res.page_addr = base_addr_q + (i << PAGE_SHIFT);
                        res.status    = ST_DONE;
                    end
                end
            end
            REQ_FREE: begin
                if (addr < base_addr_q) begin
                    res.status = ST_ADDR_INVALID;
                end else begin
                    offset = addr - base_addr_q;
                    idx    = offset >> PAGE_SHIFT;
                    if (idx >= n) begin
                        res.status = ST_ADDR_INVALID;
                    end else if (used_map[idx]) begin
                        used_map[idx] = 1'b0;
                        if (used_total > 0) used_total--;
                    end else begin
                        res.status = ST_ALREADY_FREE;
                    end
                end
            end
            default: ;
        endcase
        res.used_count = COUNT_W'(used_total);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_page_result got;
        t_page_result want;
        if (!i_rst_n) begin
            base_addr_q  = '0;
            page_count_q = '0;
            used_total   = 0;
            foreach (used_map[i]) used_map[i] = 1'b1;
            page_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE_ADDR:  base_addr_q  = i_cfg_wdata;
                    CFG_PAGE_COUNT: page_count_q = i_cfg_wdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
            // the strobe at this edge always belongs to an earlier transaction
            if (i_result_vld) begin
                got.status     = t_status'(i_status);
                got.page_addr  = i_page_addr;
                got.used_count = i_used_count;
                if (page_results.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("[%0t] unexpected result: status=%0d page_addr=%h used=%0d",
                                 $time, got.status, got.page_addr, got.used_count);
                end else begin
                    want = page_results.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("[%0t] result mismatch: expected status=%0d ",
                                     $time, want.status,
                                     "page_addr=%h used=%0d, got status=%0d ",
                                     want.page_addr, want.used_count, got.status,
                                     "page_addr=%h used=%0d",
                                     got.page_addr, got.used_count);
                    end
                end
            end
            if (i_start && !i_busy)
                page_results.push_back(serve_request(t_req'(i_req_type), i_address));
        end
        o_pending = page_results.size();
    end

endmodule

>>> bench/tb_bitmap_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator
// Drives init/alloc/free/no-op transactions and register writes into the
// page allocator; a checker instance predicts every result and counts
// mismatches, this module only paces the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator;
    import bpa_pkg::*;

    localparam int MAX_PAGES       = DEF_MAX_PAGES;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int RAND_PHASES     = 8;
    localparam int PAGE_BYTES      = 1 << PAGE_SHIFT;
    // init sweeps every map word; allow that plus some slack after the last strobe
    localparam int TAIL_CYCLES     = MAX_PAGES / WORD_BITS + 16;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 start        = 1'b0;
    logic                 busy;
    logic [1:0]           i_req_type   = REQ_NOP;
    logic [ADDR_W-1:0]    i_address    = '0;
    logic                 o_result_vld;
    logic [1:0]           o_status;
    logic [ADDR_W-1:0]    o_page_addr;
    logic [COUNT_W-1:0]   o_used_count;
    logic                 i_cfg_we     = 1'b0;
    logic                 i_cfg_idx    = CFG_BASE_ADDR;
    logic [ADDR_W-1:0]    i_cfg_wdata  = '0;

    int                   fail_count;
    int                   results_pending;

    // stimulus shaping state: idle odds per cycle and the current register values
    int unsigned          idle_pct     = 0;
    int unsigned          idle_plan [3] = '{0, 72, 6};
    logic [ADDR_W-1:0]    stim_base    = '0;
    int unsigned          stim_pages   = 0;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bitmap_page_allocator #(
        .MAX_PAGES (MAX_PAGES)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_address    (i_address),
        .o_result_vld (o_result_vld),
        .o_status     (o_status),
        .o_page_addr  (o_page_addr),
        .o_used_count (o_used_count),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    bpa_result_checker #(
        .MAX_PAGES (MAX_PAGES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req_type   (i_req_type),
        .i_address    (i_address),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_result_vld (o_result_vld),
        .i_status     (o_status),
        .i_page_addr  (o_page_addr),
        .i_used_count (o_used_count),
        .o_fail_cnt   (fail_count),
        .o_pending    (results_pending)
    );

    // Geometric idle gap; idle_pct is the chance of one more idle cycle.
    function automatic int unsigned sender_gap();
        int unsigned n;
        n = 0;
        while (n < 40 && $urandom_range(99) < idle_pct) n++;
        return n;
    endfunction

    // Present one transaction from a falling edge and hold it until accepted.
    // Returns on a falling edge; start stays high unless an idle gap follows,
    // so back-to-back transactions never lower and raise start in one step.
    task automatic issue_request(t_req req, logic [ADDR_W-1:0] addr);
        int unsigned lull;
        start      <= 1'b1;
        i_req_type <= req;
        i_address  <= addr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        lull = sender_gap();
        if (lull > 0) begin
            start <= 1'b0;
            repeat (lull) @(negedge i_clk);
        end
    endtask

    // Hold off until every predicted result has come back and the block is idle.
    task automatic drain_results();
        start <= 1'b0;
        while (results_pending != 0 || busy) @(negedge i_clk);
    endtask

    // Both registers, back to back; only called with the block idle.
    task automatic write_config(logic [ADDR_W-1:0] base, int unsigned pages);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_BASE_ADDR;
        i_cfg_wdata <= base;
        @(negedge i_clk);
        i_cfg_idx   <= CFG_PAGE_COUNT;
        i_cfg_wdata <= ADDR_W'(pages);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        stim_base   = base;
        stim_pages  = pages;
    endtask

    // Mostly allocs and frees of pages inside the managed range, with a few
    // re-inits, no-ops, out-of-range frees and raw random addresses as noise.
    task automatic random_request();
        int unsigned       roll;
        int unsigned       span;
        int unsigned       idx;
        logic [ADDR_W-1:0] addr;
        t_req              req;
        roll = $urandom_range(99);
        span = (stim_pages > MAX_PAGES) ? MAX_PAGES : stim_pages;
        if (span == 0) span = 1;
        addr = $urandom;
        if (roll < 3) begin
            req = REQ_INIT;
        end else if (roll < 6) begin
            req = REQ_NOP;
        end else if (roll < 52) begin
            req = REQ_ALLOC;
        end else begin
            req = REQ_FREE;
            if (roll < 88) begin
                // big maps: stay mostly among the low pages that allocs reach
                if ($urandom_range(3) == 0 || span <= 64)
                    idx = $urandom_range(span - 1);
                else
                    idx = $urandom_range(63);
                addr = stim_base + (idx << PAGE_SHIFT) + $urandom_range(PAGE_BYTES - 1);
            end else if (roll < 92) begin
                addr = stim_base + (span << PAGE_SHIFT) + $urandom_range(PAGE_BYTES - 1);
            end else if (roll < 96) begin
                addr = stim_base - 1 - $urandom_range(PAGE_BYTES - 1);
            end
        end
        issue_request(req, addr);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // clearing pass after reset
        @(negedge i_clk);
        while (busy) @(negedge i_clk);

        // -- directed: registers still at reset (no pages managed)
        issue_request(REQ_ALLOC, '0);                  // empty map: out of pages
        issue_request(REQ_FREE, '0);                   // page count zero: invalid
        issue_request(REQ_NOP, '1);                    // no-op reports done
        issue_request(REQ_INIT, '0);
        drain_results();

        // -- directed: eight pages high in the address space
        idle_pct = 6;
        write_config(32'hFFFF_0000, 8);
        // free before init: bit set from reset, count must not go negative
        issue_request(REQ_FREE, stim_base + 3 * PAGE_BYTES + 5);
        issue_request(REQ_ALLOC, '0);
        issue_request(REQ_INIT, '0);
        repeat (8) issue_request(REQ_ALLOC, $urandom); // fill up, then run dry
        issue_request(REQ_FREE, stim_base - 1);        // below base
        issue_request(REQ_FREE, stim_base + 8 * PAGE_BYTES);    // past last page
        issue_request(REQ_FREE, stim_base + 2 * PAGE_BYTES + 32'hFFF);  // unaligned
        issue_request(REQ_FREE, stim_base + 2 * PAGE_BYTES);    // already free
        issue_request(REQ_FREE, stim_base);            // the reserved page
        issue_request(REQ_ALLOC, '0);
        drain_results();

        // -- directed: shrink the page count after init
        write_config(stim_base, 4);
        issue_request(REQ_ALLOC, '0);
        issue_request(REQ_FREE, stim_base + 6 * PAGE_BYTES);    // outside the new count
        issue_request(REQ_FREE, stim_base + PAGE_BYTES);

        // -- random phases, each with its own register setting and idle pattern
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            // pause until everything is back before touching the registers
            drain_results();
            case (ph)
                0:       write_config('0, MAX_PAGES);
                1:       write_config(32'hFFFF_F000 - 12 * PAGE_BYTES, 16); // wraps
                2:       write_config($urandom, 1);
                3:       write_config($urandom, 0);
                4:       write_config($urandom, 8191);      // acts as the maximum
                7:       write_config('1, 8);
                default: write_config($urandom, $urandom_range(2, 40));
            endcase
            idle_pct = idle_plan[ph % 3];
            issue_request(REQ_INIT, $urandom);
            repeat (ITEMS_PER_PHASE - 1) random_request();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (every item an init sweep
    // plus the longest idle gap).
    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/bpa_pkg.sv
hdl/bpa_map_ram.sv
hdl/bpa_word_scan.sv
hdl/bitmap_page_allocator.sv
bench/bpa_result_checker.sv
bench/tb_bitmap_page_allocator.sv
